/* hw/rtl/spf_pkg.sv */
// Shared constants and types for the sample packet framer.
// No dependencies; every other file of the block except spf_ram imports this package.
`default_nettype none

package spf_pkg;

  // Framing geometry.
  localparam int unsigned SAMPLES_PER_PACKET = 10;
  localparam int unsigned PACKET_COUNT       = 2048;
  localparam int unsigned STORE_DEPTH        = SAMPLES_PER_PACKET * PACKET_COUNT;

  // Field and storage widths.
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned SADDR_W  = 15;
  localparam int unsigned PIDX_W   = 16;
  localparam int unsigned ADDR_W   = $clog2(STORE_DEPTH);
  localparam int unsigned CNT_W    = (SAMPLES_PER_PACKET > 1) ?
                                     $clog2(SAMPLES_PER_PACKET) : 1;

  // Frame delimiters.
  localparam logic [BYTE_W-1:0] FRAME_START = 8'h01;
  localparam logic [BYTE_W-1:0] FRAME_END   = 8'h02;
  localparam logic [BYTE_W-1:0] ERROR_BYTE  = 8'h00;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_HI,
    ST_LO,
    ST_END,
    ST_SUM,
    ST_ERR
  } state_e;

  // Read request from the sequencer to the sample memory.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

  // One frame byte as presented on the result ports.
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              err;
  } out_beat_t;

endpackage

`default_nettype wire

/* hw/rtl/spf_ram.sv */
// Generic single-port synchronous RAM with a registered read port.
// No dependencies.
`default_nettype none

module spf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/spf_ctrl.sv */
// Frame sequencer: walks one packet through the sample memory and emits its bytes, or an error byte.
// Depends on spf_pkg for constants, the state type and the interface structs.
`default_nettype none

module spf_ctrl import spf_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                req_i,
  input  wire logic [PIDX_W-1:0]   packet_index_i,
  input  wire logic [SAMPLE_W-1:0] rdata_i,
  output logic                     busy_o,
  output rd_req_t                  rd_o,
  output out_beat_t                beat_o
);

  localparam logic [ADDR_W-1:0] SppA     = ADDR_W'(SAMPLES_PER_PACKET);
  localparam logic [CNT_W-1:0]  LastCnt  = CNT_W'(SAMPLES_PER_PACKET - 1);

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [ADDR_W-1:0]   addr_q, addr_d;
  logic [BYTE_W-1:0]   sum_q, sum_d;
  logic                in_range;
  logic                last_sample;
  logic [ADDR_W-1:0]   base;

  assign in_range    = 32'(packet_index_i) < 32'(PACKET_COUNT);
  assign base        = ADDR_W'(packet_index_i) * SppA;
  assign last_sample = (cnt_q == LastCnt);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_i) begin
          state_d = in_range ? ST_START : ST_ERR;
        end
      end
      ST_START: state_d = ST_HI;
      ST_HI:    state_d = ST_LO;
      ST_LO:    state_d = last_sample ? ST_END : ST_HI;
      ST_END:   state_d = ST_SUM;
      ST_SUM:   state_d = ST_IDLE;
      ST_ERR:   state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath updates.
  always_comb begin
    cnt_d        = cnt_q;
    addr_d       = addr_q;
    sum_d        = sum_q;
    rd_o.en      = 1'b0;
    rd_o.addr    = addr_q;
    beat_o.valid = 1'b0;
    beat_o.data  = ERROR_BYTE;
    beat_o.last  = 1'b0;
    beat_o.err   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (req_i && in_range) begin
          addr_d = base;
          sum_d  = '0;
        end
      end
      ST_START: begin
        beat_o.valid = 1'b1;
        beat_o.data  = FRAME_START;
        rd_o.en      = 1'b1;
        addr_d       = addr_q + ADDR_W'(1);
      end
      ST_HI: begin
        beat_o.valid = 1'b1;
        beat_o.data  = rdata_i[SAMPLE_W-1:BYTE_W];
        sum_d        = sum_q + rdata_i[SAMPLE_W-1:BYTE_W];
      end
      ST_LO: begin
        beat_o.valid = 1'b1;
        beat_o.data  = rdata_i[BYTE_W-1:0];
        sum_d        = sum_q + rdata_i[BYTE_W-1:0];
        cnt_d        = cnt_q + CNT_W'(1);
        if (!last_sample) begin
          rd_o.en = 1'b1;
          addr_d  = addr_q + ADDR_W'(1);
        end
      end
      ST_END: begin
        beat_o.valid = 1'b1;
        beat_o.data  = FRAME_END;
      end
      ST_SUM: begin
        beat_o.valid = 1'b1;
        beat_o.data  = sum_q;
        beat_o.last  = 1'b1;
      end
      ST_ERR: begin
        beat_o.valid = 1'b1;
        beat_o.data  = ERROR_BYTE;
        beat_o.last  = 1'b1;
        beat_o.err   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      sum_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
  end

endmodule

`default_nettype wire

/* hw/rtl/sample_packet_framer_top.sv */
// Sample packet framer: a write transaction yields nothing.
// A frame transaction yields 2*SAMPLES_PER_PACKET+3 bytes (23), one per cycle, starting the
// cycle after acceptance; busy_o stays high through the last byte and drops after it.
// An out-of-range packet index yields one error byte the next cycle.
// The receiver cannot stall the byte stream. Reset is asynchronous and active low; it clears
// the sequencer and checksum, and the sample memory has no reset and must be written first.
`default_nettype none

module sample_packet_framer_top import spf_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  output logic                     busy_o,
  input  wire logic                mode_i,
  input  wire logic [SADDR_W-1:0]  sample_address_i,
  input  wire logic [SAMPLE_W-1:0] sample_value_i,
  input  wire logic [PIDX_W-1:0]   packet_index_i,
  output logic                     valid_o,
  output logic [BYTE_W-1:0]        out_byte_o,
  output logic                     last_byte_o,
  output logic                     index_error_o
);

  logic                accept;
  logic                frame_req;
  logic                wr_en;
  logic                ram_en;
  logic [ADDR_W-1:0]   ram_addr;
  logic [SAMPLE_W-1:0] ram_rdata;
  rd_req_t             rd_req;
  out_beat_t           beat;

  // A transaction is taken whenever the sequencer is idle. Writes go straight
  // into the memory in the same cycle; a write beyond the store is dropped.
  assign accept    = start_i && !busy_o;
  assign frame_req = accept && mode_i;
  assign wr_en     = accept && !mode_i &&
                     (32'(sample_address_i) < 32'(STORE_DEPTH));

  // The memory has one port. Writes are accepted only while the sequencer is
  // idle and it issues reads only while busy, so the two never collide and no
  // forwarding is needed.
  assign ram_en   = wr_en || rd_req.en;
  assign ram_addr = wr_en ? ADDR_W'(sample_address_i) : rd_req.addr;

  spf_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (wr_en),
    .addr_i  (ram_addr),
    .wdata_i (sample_value_i),
    .rdata_o (ram_rdata)
  );

  // The sequencer issues each sample's read ahead of its high byte; the registered read
  // data holds while the high byte goes out and is consumed by the low byte.
  spf_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (frame_req),
    .packet_index_i (packet_index_i),
    .rdata_i        (ram_rdata),
    .busy_o         (busy_o),
    .rd_o           (rd_req),
    .beat_o         (beat)
  );

  assign valid_o       = beat.valid;
  assign out_byte_o    = beat.data;
  assign last_byte_o   = beat.last;
  assign index_error_o = beat.err;

endmodule

`default_nettype wire

/* hw/rtl/spf_checker.sv */
// Port-level checks for the sample packet framer, bound to its top level.
// Depends on spf_pkg for widths and frame constants.
`default_nettype none

module spf_checker import spf_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                start_i,
  input wire logic                busy_o,
  input wire logic                mode_i,
  input wire logic [SADDR_W-1:0]  sample_address_i,
  input wire logic [SAMPLE_W-1:0] sample_value_i,
  input wire logic [PIDX_W-1:0]   packet_index_i,
  input wire logic                valid_o,
  input wire logic [BYTE_W-1:0]   out_byte_o,
  input wire logic                last_byte_o,
  input wire logic                index_error_o
);

  // A frame transaction always produces a byte in the very next cycle.
  a_frame_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && mode_i |=> valid_o && busy_o)
    else $error("frame transaction did not start output");

  // A write transaction never produces a byte and leaves the block idle.
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && !mode_i |=> !valid_o && !busy_o)
    else $error("write transaction produced output");

  // The closing byte of a transaction is followed by an idle cycle.
  a_last_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_byte_o |=> !valid_o && !busy_o)
    else $error("output continued after last byte");

  // An error result is a lone zero byte that closes the transaction.
  a_error_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && index_error_o |-> last_byte_o && (out_byte_o == ERROR_BYTE))
    else $error("malformed error result");

  // A frame opens with the start delimiter.
  a_start_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && mode_i && (32'(packet_index_i) < 32'(PACKET_COUNT))
    |=> valid_o && (out_byte_o == FRAME_START) && !last_byte_o)
    else $error("frame did not open with start byte");

endmodule

bind sample_packet_framer_top spf_checker u_spf_checker (.*);

`default_nettype wire

/* dv/sample_packet_framer_checker.sv */
`timescale 1ns / 100ps
// Testbench-side package of transaction codes and the framer checker, which predicts every
// frame from its own copy of the sample store. Depends on spf_pkg from the RTL.

package spf_tb_pkg;

  typedef enum logic {
    MODE_WRITE = 1'b0,
    MODE_FRAME = 1'b1
  } xact_mode_e;

endpackage

module sample_packet_framer_checker import spf_pkg::*, spf_tb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_o,
  input  logic                mode_i,
  input  logic [SADDR_W-1:0]  sample_address_i,
  input  logic [SAMPLE_W-1:0] sample_value_i,
  input  logic [PIDX_W-1:0]   packet_index_i,
  input  logic                valid_o,
  input  logic [BYTE_W-1:0]   out_byte_o,
  input  logic                last_byte_o,
  input  logic                index_error_o,
  output int                  mismatch_count_o,
  output int                  bytes_due_o,
  output int                  bytes_seen_o,
  output int                  frames_seen_o
);

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              err;
  } frame_byte_t;

  logic [SAMPLE_W-1:0] sample_mirror [STORE_DEPTH];
  frame_byte_t         bytes_due [$];
  int                  mismatches;
  int                  bytes_seen;
  int                  frames_seen;

  // Applies one accepted transaction to the mirrored store and queues the bytes it must produce.
  function automatic void predict_frame(input xact_mode_e mode, input logic [SADDR_W-1:0] addr,
                                        input logic [SAMPLE_W-1:0] value,
                                        input logic [PIDX_W-1:0] pidx);
    logic [BYTE_W-1:0]   sum;
    logic [SAMPLE_W-1:0] word;
    int unsigned         base;
    if (mode == MODE_WRITE) begin
      if (addr < STORE_DEPTH) begin
        sample_mirror[addr] = value;
      end
    end else if (pidx >= PACKET_COUNT) begin
      bytes_due.push_back('{data: ERROR_BYTE, last: 1'b1, err: 1'b1});
    end else begin
      sum  = '0;
      base = int'(pidx) * SAMPLES_PER_PACKET;
      bytes_due.push_back('{data: FRAME_START, last: 1'b0, err: 1'b0});
      for (int s = 0; s < SAMPLES_PER_PACKET; s++) begin
        word = sample_mirror[base + s];
        bytes_due.push_back('{data: word[15:8], last: 1'b0, err: 1'b0});
        bytes_due.push_back('{data: word[7:0], last: 1'b0, err: 1'b0});
        sum = sum + word[15:8] + word[7:0];
      end
      bytes_due.push_back('{data: FRAME_END, last: 1'b0, err: 1'b0});
      bytes_due.push_back('{data: sum, last: 1'b1, err: 1'b0});
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    frame_byte_t due;
    if (!rst_ni) begin
      bytes_due.delete();
      mismatches       = 0;
      bytes_seen       = 0;
      frames_seen      = 0;
      mismatch_count_o <= 0;
      bytes_due_o      <= 0;
      bytes_seen_o     <= 0;
      frames_seen_o    <= 0;
    end else begin
      // Results are compared before the transaction of this edge is predicted.
      if (valid_o) begin
        bytes_seen++;
        if (last_byte_o === 1'b1) begin
          frames_seen++;
        end
        if (bytes_due.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: unexpected byte %02h last=%b err=%b with nothing due", $realtime,
                     out_byte_o, last_byte_o, index_error_o);
          end
          mismatches++;
        end else begin
          due = bytes_due.pop_front();
          if (out_byte_o !== due.data || last_byte_o !== due.last ||
              index_error_o !== due.err) begin
            if (mismatches < 10) begin
              $display("%0t: byte mismatch: expected %02h last=%b err=%b, got %02h last=%b err=%b",
                       $realtime, due.data, due.last, due.err,
                       out_byte_o, last_byte_o, index_error_o);
            end
            mismatches++;
          end
        end
      end
      if (start_i && !busy_o) begin
        predict_frame(xact_mode_e'(mode_i), sample_address_i, sample_value_i, packet_index_i);
      end
      mismatch_count_o <= mismatches;
      bytes_due_o      <= bytes_due.size();
      bytes_seen_o     <= bytes_seen;
      frames_seen_o    <= frames_seen;
    end
  end

endmodule

/* dv/sample_packet_framer_top_tb.sv */
`timescale 1ns / 100ps
// Top of the framer testbench: clock, reset, stimulus and the final verdict.
// Depends on spf_pkg, the framer RTL and the checker file with spf_tb_pkg.

module sample_packet_framer_top_tb import spf_pkg::*, spf_tb_pkg::*;;

  // The checker counts mismatches; this module only drives transactions and decides the verdict.
  localparam int RANDOM_ITEMS = 220;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_TIME  = 30;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic                mode_i;
  logic [SADDR_W-1:0]  sample_address_i;
  logic [SAMPLE_W-1:0] sample_value_i;
  logic [PIDX_W-1:0]   packet_index_i;
  logic                valid_o;
  logic [BYTE_W-1:0]   out_byte_o;
  logic                last_byte_o;
  logic                index_error_o;

  int mismatch_count;
  int bytes_due;
  int bytes_seen;
  int frames_seen;

  // Stimulus bookkeeping for the summary lines.
  int writes_stored;
  int writes_dropped;
  int frames_asked;
  int frames_refused;
  int stim_items;
  int calm_left;
  int cycle_count;

  // Packets whose every sample has been written; only these may be framed.
  int ready_packets [$];

  sample_packet_framer_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .mode_i           (mode_i),
    .sample_address_i (sample_address_i),
    .sample_value_i   (sample_value_i),
    .packet_index_i   (packet_index_i),
    .valid_o          (valid_o),
    .out_byte_o       (out_byte_o),
    .last_byte_o      (last_byte_o),
    .index_error_o    (index_error_o)
  );

  sample_packet_framer_checker u_frame_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .mode_i           (mode_i),
    .sample_address_i (sample_address_i),
    .sample_value_i   (sample_value_i),
    .packet_index_i   (packet_index_i),
    .valid_o          (valid_o),
    .out_byte_o       (out_byte_o),
    .last_byte_o      (last_byte_o),
    .index_error_o    (index_error_o),
    .mismatch_count_o (mismatch_count),
    .bytes_due_o      (bytes_due),
    .bytes_seen_o     (bytes_seen),
    .frames_seen_o    (frames_seen)
  );

  initial begin
    clk_i = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  // Watchdog: a hung handshake or a frame that never finishes ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d bytes still due", cycle_count, bytes_due);
      $display("sample_packet_framer_top_tb: errors");
      $finish;
    end
  end

  // Sample values lean toward all zeros and all ones so that byte carries in the checksum
  // are exercised as well as random data.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int r;
    r = $urandom_range(9);
    if (r == 0) begin
      return '0;
    end else if (r == 1) begin
      return '1;
    end
    return SAMPLE_W'($urandom);
  endfunction

  // Presents one transaction and holds it until the framer takes it. A random gap comes
  // first; since the framer may still be streaming a frame, the gap lands on any phase of it.
  // start_i is left high afterwards, so back-to-back transactions present no idle gap between them.
  task automatic issue(input xact_mode_e mode, input logic [SADDR_W-1:0] addr,
                       input logic [SAMPLE_W-1:0] value, input logic [PIDX_W-1:0] pidx);
    int gap;
    int r;
    gap = 0;
    if (calm_left > 0) begin
      calm_left--;
    end else begin
      r = $urandom_range(99);
      if (r < 4) begin
        calm_left = $urandom_range(10, 30);
      end else if (r < 55) begin
        gap = 0;
      end else if (r < 90) begin
        gap = $urandom_range(1, 3);
      end else begin
        gap = $urandom_range(10, 40);
      end
    end
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i          <= 1'b1;
    mode_i           <= mode;
    sample_address_i <= addr;
    sample_value_i   <= value;
    packet_index_i   <= pidx;
    // busy_o is stable at the falling edge; low there means the next rising edge accepts.
    do @(negedge clk_i); while (busy_o);
    @(posedge clk_i);
    if (mode == MODE_WRITE) begin
      if (addr < STORE_DEPTH) begin
        writes_stored++;
        stim_items++;
      end else begin
        writes_dropped++;
      end
    end else begin
      frames_asked++;
      stim_items++;
      if (pidx >= PACKET_COUNT) begin
        frames_refused++;
      end
    end
  endtask

  task automatic write_sample(input logic [SADDR_W-1:0] addr, input logic [SAMPLE_W-1:0] value);
    issue(MODE_WRITE, addr, value, PIDX_W'($urandom));
  endtask

  task automatic request_frame(input logic [PIDX_W-1:0] pidx);
    issue(MODE_FRAME, SADDR_W'($urandom), SAMPLE_W'($urandom), pidx);
  endtask

  // Holds the sender off until the framer is idle and every predicted byte has arrived.
  task automatic drain_results();
    start_i <= 1'b0;
    do @(negedge clk_i); while (bytes_due != 0 || busy_o);
    @(posedge clk_i);
  endtask

  // A stray transaction: a write anywhere in the address range (possibly beyond the store)
  // or a request for a packet number past the end.
  task automatic stray_item();
    if ($urandom_range(1) == 0) begin
      write_sample(SADDR_W'($urandom_range(0, 32767)), pick_sample());
    end else begin
      request_frame(PIDX_W'($urandom_range(PACKET_COUNT, 65535)));
    end
  endtask

  initial begin
    logic [SAMPLE_W-1:0] corner_values [SAMPLES_PER_PACKET];
    int                  pkt;
    int                  r;
    int                  n;

    corner_values = '{16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00, 16'h8001,
                      16'h7FFE, 16'h5555, 16'hAAAA, 16'h0100, 16'h00FE};

    rst_ni           = 1'b0;
    start_i          <= 1'b0;
    mode_i           <= MODE_WRITE;
    sample_address_i <= '0;
    sample_value_i   <= '0;
    packet_index_i   <= '0;
    cycle_count      = 0;
    calm_left        = 0;
    writes_stored    = 0;
    writes_dropped   = 0;
    frames_asked     = 0;
    frames_refused   = 0;
    stim_items       = 0;

    // Reset is released away from the rising edge to keep the asynchronous release clean.
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Directed part. Packet 0 holds corner words, and the two writes beyond the store must be
    // dropped without touching it. The last packet is all ones, so its checksum wraps
    // several times. Then the first index past the end and the largest index are refused.
    for (int s = 0; s < SAMPLES_PER_PACKET; s++) begin
      write_sample(SADDR_W'(s), corner_values[s]);
    end
    write_sample(SADDR_W'(STORE_DEPTH), 16'h1234);
    write_sample('1, '1);
    request_frame('0);
    for (int s = 0; s < SAMPLES_PER_PACKET; s++) begin
      write_sample(SADDR_W'((PACKET_COUNT - 1) * SAMPLES_PER_PACKET + s), '1);
    end
    request_frame(PIDX_W'(PACKET_COUNT - 1));
    request_frame(PIDX_W'(PACKET_COUNT));
    request_frame('1);
    ready_packets.push_back(0);
    ready_packets.push_back(PACKET_COUNT - 1);
    drain_results();

    // Random part. Most of it is complete packets: all samples written, with the odd stray
    // transaction mixed in, then one or two frame requests. The rest repeats requests for
    // packets already filled, sends stray writes or refused indexes, or leaves a packet partly
    // written, which is then never requested unless a later sequence fills it.
    while (stim_items < RANDOM_ITEMS) begin
      r = $urandom_range(99);
      if (r < 70) begin
        pkt = ($urandom_range(9) == 0) ? ($urandom_range(1) * (PACKET_COUNT - 1)) :
                                         $urandom_range(0, PACKET_COUNT - 1);
        for (int s = 0; s < SAMPLES_PER_PACKET; s++) begin
          if ($urandom_range(99) < 10) begin
            stray_item();
          end
          write_sample(SADDR_W'(pkt * SAMPLES_PER_PACKET + s), pick_sample());
        end
        request_frame(PIDX_W'(pkt));
        if ($urandom_range(99) < 25) begin
          request_frame(PIDX_W'(pkt));
        end
        ready_packets.push_back(pkt);
      end else if (r < 86) begin
        stray_item();
      end else if (r < 94) begin
        request_frame(PIDX_W'(ready_packets[$urandom_range(0, ready_packets.size() - 1)]));
      end else begin
        pkt = $urandom_range(0, PACKET_COUNT - 1);
        n   = $urandom_range(1, SAMPLES_PER_PACKET - 1);
        for (int s = 0; s < n; s++) begin
          write_sample(SADDR_W'(pkt * SAMPLES_PER_PACKET + s), pick_sample());
        end
      end
      if ($urandom_range(99) < 8) begin
        drain_results();
      end
    end

    drain_results();
    repeat (SETTLE_TIME) @(posedge clk_i);

    $display("Run covered %0d stored and %0d dropped sample writes, %0d frame requests (%0d refused).",
             writes_stored, writes_dropped, frames_asked, frames_refused);
    $display("Checked %0d result bytes closing %0d frames; %0d mismatches, %0d bytes never seen.",
             bytes_seen, frames_seen, mismatch_count, bytes_due);
    if (mismatch_count == 0 && bytes_due == 0) begin
      $display("sample_packet_framer_top_tb: clean");
    end else begin
      $display("sample_packet_framer_top_tb: errors");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/spf_pkg.sv
hw/rtl/spf_ram.sv
hw/rtl/spf_ctrl.sv
hw/rtl/sample_packet_framer_top.sv
hw/rtl/spf_checker.sv
dv/sample_packet_framer_checker.sv
dv/sample_packet_framer_top_tb.sv
